>>> sv/mee_pkg.sv
package mee_pkg;

  localparam int unsigned NODE_SPACE_DEF    = 4096;
  localparam int unsigned EDGE_CAPACITY_DEF = 8192;
  localparam int unsigned MAX_RING_DEF      = 16;
  localparam int unsigned CMD_DEPTH         = 4;
  localparam int unsigned RES_DEPTH         = 2;

  localparam int unsigned NODE_W  = 13;
  localparam int unsigned LOCAL_W = 12;
  localparam int unsigned EIDX_W  = 13;
  localparam int unsigned ELEM_W  = 16;

  typedef enum logic [1:0] {
    KIND_NODE = 2'd0,
    KIND_NEW  = 2'd1,
    KIND_SEEN = 2'd2
  } kind_e;

  // work handed from front to back
  typedef struct packed {
    logic               is_edge;
    logic               last;
    logic [LOCAL_W-1:0] local_node;
    logic [LOCAL_W-1:0] p;
    logic [LOCAL_W-1:0] q;
    logic [ELEM_W-1:0]  elem;
    logic               ovf;
  } cmd_t;

  typedef struct packed {
    kind_e              kind;
    logic               last;
    logic [LOCAL_W-1:0] local_node;
    logic [EIDX_W-1:0]  edge_index;
    logic [LOCAL_W-1:0] edge_first;
    logic [LOCAL_W-1:0] edge_second;
    logic [ELEM_W-1:0]  elem;
    logic               ovf;
  } res_t;

endpackage

>>> sv/mee_fifo.sv
module mee_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] rdata_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (do_pop)  rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule

>>> sv/mee_front.sv
module mee_front #(
  parameter int unsigned NODE_SPACE = mee_pkg::NODE_SPACE_DEF,
  parameter int unsigned MAX_RING   = mee_pkg::MAX_RING_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [mee_pkg::NODE_W-1:0]  node_number_i,
  input  logic                        end_of_element_i,
  output mee_pkg::cmd_t               cmd_o,
  output logic                        cmd_push_o,
  input  logic                        cmd_full_i
);
  import mee_pkg::*;

  localparam int unsigned NW = (NODE_SPACE > 1) ? $clog2(NODE_SPACE) : 1;
  localparam int unsigned RA = (MAX_RING > 1) ? $clog2(MAX_RING) : 1;
  localparam int unsigned LW = $clog2(MAX_RING + 1);

  typedef enum logic [5:0] {
    F_CLEAR = 6'b000001,
    F_IDLE  = 6'b000010,
    F_RMW   = 6'b000100,
    F_EMIT  = 6'b001000,
    F_RD    = 6'b010000,
    F_ED    = 6'b100000
  } fstate_e;

  fstate_e state_q, state_d;

  logic [LOCAL_W:0]   node_mem [NODE_SPACE];
  logic [LOCAL_W-1:0] ring_mem [MAX_RING];

  logic [NW-1:0]      clr_q, addr_q;
  logic               last_q, nvalid_q, ovf_q;
  logic [LOCAL_W:0]   node_rd_q;
  logic [LOCAL_W-1:0] node_cnt_q, local_q, first_q, p_q, ring_rd_q;
  logic [LW-1:0]      ring_len_q, i_q, nxt;
  logic [ELEM_W-1:0]  elem_q;

  logic               in_ok, accept;
  logic [NW-1:0]      node_ra;
  logic               node_we;
  logic [NW-1:0]      node_wa;
  logic [LOCAL_W:0]   node_wd;
  logic [LOCAL_W-1:0] loc, q_sel;
  logic               ring_we, ring_has;
  logic [RA-1:0]      ring_ra;

  assign full_o   = (state_q != F_IDLE);
  assign accept   = push_i && (state_q == F_IDLE);
  assign in_ok    = (node_number_i != '0) && (32'(node_number_i) <= NODE_SPACE);
  assign node_ra  = NW'(node_number_i - NODE_W'(1));
  assign nxt      = i_q + 1'b1;
  assign ring_has = (nxt < ring_len_q);
  assign ring_ra  = ring_has ? nxt[RA-1:0] : '0;
  assign loc      = node_rd_q[LOCAL_W] ? node_rd_q[LOCAL_W-1:0] : node_cnt_q;
  assign ring_we  = (state_q == F_RMW) && nvalid_q && (ring_len_q < LW'(MAX_RING));
  assign q_sel    = ring_has ? ring_rd_q : first_q;

  always_comb begin
    node_we = 1'b0;
    node_wa = addr_q;
    node_wd = {1'b1, node_cnt_q};
    if (state_q == F_CLEAR) begin
      node_we = 1'b1;
      node_wa = clr_q;
      node_wd = '0;
    end else if (state_q == F_RMW && nvalid_q && !node_rd_q[LOCAL_W]) begin
      node_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_rd_q <= node_mem[node_ra];
    if (ring_we) ring_mem[ring_len_q[RA-1:0]] <= loc;
    ring_rd_q <= ring_mem[ring_ra];
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.local_node = local_q;
    cmd_o.elem       = elem_q;
    cmd_push_o       = 1'b0;
    case (state_q)
      F_EMIT: begin
        cmd_push_o = 1'b1;
        cmd_o.last = !(last_q && ring_len_q != '0);
        cmd_o.ovf  = ovf_q;
      end
      F_ED: begin
        cmd_push_o    = 1'b1;
        cmd_o.is_edge = 1'b1;
        cmd_o.last    = (nxt == ring_len_q);
        cmd_o.p       = p_q;
        cmd_o.q       = q_sel;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_CLEAR: if (clr_q == NW'(NODE_SPACE - 1)) state_d = F_IDLE;
      F_IDLE:  if (accept) state_d = F_RMW;
      F_RMW:   state_d = F_EMIT;
      F_EMIT: begin
        if (!cmd_full_i) state_d = (last_q && ring_len_q != '0) ? F_RD : F_IDLE;
      end
      F_RD:    state_d = F_ED;
      F_ED: begin
        if (!cmd_full_i) state_d = (nxt == ring_len_q) ? F_IDLE : F_RD;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_CLEAR;
      clr_q      <= '0;
      node_cnt_q <= '0;
      ring_len_q <= '0;
      elem_q     <= '0;
      i_q        <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        F_CLEAR: clr_q <= clr_q + 1'b1;
        F_RMW: begin
          if (nvalid_q) begin
            if (!node_rd_q[LOCAL_W]) node_cnt_q <= node_cnt_q + 1'b1;
            if (ring_we) ring_len_q <= ring_len_q + 1'b1;
          end
        end
        F_EMIT: begin
          if (!cmd_full_i && last_q) begin
            if (ring_len_q == '0) elem_q <= elem_q + 1'b1;
            i_q <= '0;
          end
        end
        F_ED: begin
          if (!cmd_full_i) begin
            i_q <= nxt;
            if (nxt == ring_len_q) begin
              elem_q     <= elem_q + 1'b1;
              ring_len_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q   <= node_ra;
      last_q   <= end_of_element_i;
      nvalid_q <= in_ok;
    end
    if (state_q == F_RMW) begin
      local_q <= nvalid_q ? loc : '0;
      ovf_q   <= !ring_we;
      if (ring_we && ring_len_q == '0) first_q <= loc;
    end
    if (state_q == F_EMIT) p_q <= first_q;
    if (state_q == F_ED && !cmd_full_i) p_q <= q_sel;
  end
endmodule

>>> sv/mee_back.sv
module mee_back #(
  parameter int unsigned EDGE_CAPACITY = mee_pkg::EDGE_CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mee_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  output mee_pkg::res_t res_o,
  output logic          res_push_o,
  input  logic          res_full_i
);
  import mee_pkg::*;

  localparam int unsigned EA = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
  localparam int unsigned CW = $clog2(EDGE_CAPACITY + 1);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_RD   = 4'b0010,
    B_CMP  = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_e;

  bstate_e state_q;

  logic [2*LOCAL_W-1:0] edge_mem [EDGE_CAPACITY];
  logic [2*LOCAL_W-1:0] rd_q;
  logic [CW-1:0]        k_q, cnt_q;
  cmd_t                 cmd_q;
  res_t                 res_q;

  logic [LOCAL_W-1:0] ea, eb, lo, hi, elo, ehi;
  logic               match, edge_we;

  assign ea      = rd_q[2*LOCAL_W-1:LOCAL_W];
  assign eb      = rd_q[LOCAL_W-1:0];
  assign lo      = (cmd_q.p < cmd_q.q) ? cmd_q.p : cmd_q.q;
  assign hi      = (cmd_q.p < cmd_q.q) ? cmd_q.q : cmd_q.p;
  assign elo     = (ea < eb) ? ea : eb;
  assign ehi     = (ea < eb) ? eb : ea;
  assign match   = (elo == lo) && (ehi == hi);
  assign edge_we = (state_q == B_RD) && (k_q == cnt_q) && (cnt_q < CW'(EDGE_CAPACITY));

  assign cmd_pop_o  = (state_q == B_IDLE) && !cmd_empty_i;
  assign res_push_o = (state_q == B_OUT);
  assign res_o      = res_q;

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[cnt_q[EA-1:0]] <= {cmd_q.p, cmd_q.q};
    rd_q <= edge_mem[k_q[EA-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (!cmd_empty_i) begin
            k_q     <= '0;
            state_q <= cmd_i.is_edge ? B_RD : B_OUT;
          end
        end
        B_RD: begin
          if (k_q == cnt_q) begin
            if (edge_we) cnt_q <= cnt_q + 1'b1;
            state_q <= B_OUT;
          end else begin
            state_q <= B_CMP;
          end
        end
        B_CMP: begin
          if (match) state_q <= B_OUT;
          else begin
            k_q     <= k_q + 1'b1;
            state_q <= B_RD;
          end
        end
        B_OUT: if (!res_full_i) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_q <= cmd_i;
          res_q <= '{kind: KIND_NODE, last: cmd_i.last, local_node: cmd_i.local_node,
                     edge_index: '0, edge_first: '0, edge_second: '0,
                     elem: cmd_i.elem, ovf: cmd_i.ovf};
        end
      end
      B_RD: begin
        if (k_q == cnt_q) begin
          res_q <= '{kind: KIND_NEW, last: res_q.last, local_node: res_q.local_node,
                     edge_index: edge_we ? EIDX_W'(32'(cnt_q)) : '0,
                     edge_first: cmd_q.p, edge_second: cmd_q.q,
                     elem: res_q.elem, ovf: !edge_we};
        end
      end
      B_CMP: begin
        if (match) begin
          res_q <= '{kind: KIND_SEEN, last: res_q.last, local_node: res_q.local_node,
                     edge_index: EIDX_W'(32'(k_q)), edge_first: ea, edge_second: eb,
                     elem: res_q.elem, ovf: 1'b0};
        end
      end
      default: ;
    endcase
  end
endmodule

>>> sv/polygon_mesh_edge_extractor_core.sv
// a node transfer goes through the front states F_RMW and F_EMIT, the command queue, then the back
// states B_IDLE and B_OUT into the result queue; a new input is taken only in F_IDLE, after the last
// is emitted; a polygon close adds F_RD and F_ED per ring edge, and the back repeats B_RD and B_CMP
// per stored edge scanned (linear search of the edge memory); reset: asynchronous, active low;
// afterwards a clearing pass over all NODE_SPACE entries wipes the node table while full stays high
module polygon_mesh_edge_extractor_core #(
  parameter int unsigned NODE_SPACE    = mee_pkg::NODE_SPACE_DEF,
  parameter int unsigned EDGE_CAPACITY = mee_pkg::EDGE_CAPACITY_DEF,
  parameter int unsigned MAX_RING      = mee_pkg::MAX_RING_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [mee_pkg::NODE_W-1:0]  node_number_i,
  input  logic                        end_of_element_i,
  input  logic                        pop,
  output logic                        empty,
  output logic [1:0]                  result_kind_o,
  output logic                        last_result_o,
  output logic [mee_pkg::LOCAL_W-1:0] local_node_o,
  output logic [mee_pkg::EIDX_W-1:0]  edge_index_o,
  output logic [mee_pkg::LOCAL_W-1:0] edge_first_o,
  output logic [mee_pkg::LOCAL_W-1:0] edge_second_o,
  output logic [mee_pkg::ELEM_W-1:0]  element_index_o,
  output logic                        overflow_o
);
  import mee_pkg::*;

  // front to back command queue
  cmd_t front_cmd, back_cmd;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  // back to result queue
  res_t back_res, out_res;
  logic res_push, res_full;

  // front: node numbering, ring capture, edge walk on polygon close
  mee_front #(
    .NODE_SPACE (NODE_SPACE),
    .MAX_RING   (MAX_RING)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .node_number_i    (node_number_i),
    .end_of_element_i (end_of_element_i),
    .cmd_o            (front_cmd),
    .cmd_push_o       (cmd_push),
    .cmd_full_i       (cmd_full)
  );

  mee_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .full_o  (cmd_full),
    .wdata_i (front_cmd),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .rdata_o (back_cmd)
  );

  // back: edge lookup and insertion
  mee_back #(
    .EDGE_CAPACITY (EDGE_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (back_res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue decouples the back from the consumer
  mee_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (back_res),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (out_res)
  );

  assign result_kind_o   = out_res.kind;
  assign last_result_o   = out_res.last;
  assign local_node_o    = out_res.local_node;
  assign edge_index_o    = out_res.edge_index;
  assign edge_first_o    = out_res.edge_first;
  assign edge_second_o   = out_res.edge_second;
  assign element_index_o = out_res.elem;
  assign overflow_o      = out_res.ovf;
endmodule

>>> bench/tb_polygon_mesh_edge_extractor_core.sv
`timescale 1ns / 100ps

module tb_polygon_mesh_edge_extractor_core;
  import mee_pkg::*;

  localparam int unsigned NSPACE = NODE_SPACE_DEF;
  localparam int unsigned ECAP   = EDGE_CAPACITY_DEF;
  localparam int unsigned RING   = MAX_RING_DEF;

  // mesh edge predictor and queue of expected result transfers
  class mesh_scoreboard;
    bit             node_seen [NSPACE];
    logic [11:0]    node_local[NSPACE];
    int unsigned    node_cnt;
    int unsigned    edge_id[bit [23:0]];
    logic [11:0]    edge_a[$];
    logic [11:0]    edge_b[$];
    logic [11:0]    ring[RING];
    int unsigned    ring_len;
    logic [15:0]    elem_cnt;
    res_t           pending[$];
    int unsigned    errors;

    function void add(kind_e k, logic [11:0] loc, logic [12:0] idx, logic [11:0] a,
                      logic [11:0] b, logic ovf);
      res_t r;
      r.kind = k; r.last = 1'b0; r.local_node = loc; r.edge_index = idx;
      r.edge_first = a; r.edge_second = b; r.elem = elem_cnt; r.ovf = ovf;
      pending.insert(pending.size(), r);
    endfunction

    // one accepted node transfer: numbering, ring entry, edge walk on close
    function void note_node(logic [12:0] num, logic eoe);
      logic [11:0] loc, p, q, lo, hi;
      logic        ovf;
      bit [23:0]   key;
      int unsigned id;
      loc = '0; ovf = 1'b0;
      if (num == 0 || num > NSPACE) begin
        ovf = 1'b1;
      end else begin
        if (!node_seen[num-1]) begin
          node_seen[num-1] = 1'b1;
          node_local[num-1] = node_cnt[11:0];
          node_cnt++;
        end
        loc = node_local[num-1];
        if (ring_len < RING) begin
          ring[ring_len] = loc;
          ring_len++;
        end else begin
          ovf = 1'b1;
        end
      end
      add(KIND_NODE, loc, '0, '0, '0, ovf);
      if (eoe) begin
        for (int i = 0; i < ring_len; i++) begin
          p = ring[i];
          q = ring[(i + 1 < ring_len) ? i + 1 : 0];
          lo = (p < q) ? p : q;
          hi = (p < q) ? q : p;
          key = {lo, hi};
          if (edge_id.exists(key)) begin
            id = edge_id[key];
            add(KIND_SEEN, loc, id[12:0], edge_a[id], edge_b[id], 1'b0);
          end else if (edge_a.size() < ECAP) begin
            id = edge_a.size();
            edge_id[key] = id;
            edge_a.insert(edge_a.size(), p);
            edge_b.insert(edge_b.size(), q);
            add(KIND_NEW, loc, id[12:0], p, q, 1'b0);
          end else begin
            add(KIND_NEW, loc, '0, p, q, 1'b1);
          end
        end
        ring_len = 0;
        elem_cnt++;
      end
      pending[pending.size()-1].last = 1'b1;
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task check_result(res_t got);
      res_t w;
      if (pending.size() == 0) begin
        report("unexpected result", got.kind, 0);
        return;
      end
      w = pending.pop_front();
      if (got.kind != w.kind) report("result_kind", got.kind, w.kind);
      if (got.last != w.last) report("last_result", got.last, w.last);
      if (got.local_node != w.local_node) report("local_node", got.local_node, w.local_node);
      if (got.edge_index != w.edge_index) report("edge_index", got.edge_index, w.edge_index);
      if (got.edge_first != w.edge_first) report("edge_first", got.edge_first, w.edge_first);
      if (got.edge_second != w.edge_second)
        report("edge_second", got.edge_second, w.edge_second);
      if (got.elem != w.elem) report("element_index", got.elem, w.elem);
      if (got.ovf != w.ovf) report("overflow", got.ovf, w.ovf);
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [NODE_W-1:0] node_number_i = '0;
  logic              end_of_element_i = 1'b0;
  logic              pop = 1'b0;
  logic              empty;
  logic [1:0]        result_kind_o;
  logic              last_result_o;
  logic [LOCAL_W-1:0] local_node_o;
  logic [EIDX_W-1:0] edge_index_o;
  logic [LOCAL_W-1:0] edge_first_o;
  logic [LOCAL_W-1:0] edge_second_o;
  logic [ELEM_W-1:0] element_index_o;
  logic              overflow_o;

  mesh_scoreboard sb = new();
  bit hold_req = 1'b0;  // asks the receiver for one long hold-off

  polygon_mesh_edge_extractor_core dut (
    .clk_i, .rst_ni, .push, .full, .node_number_i, .end_of_element_i,
    .pop, .empty, .result_kind_o, .last_result_o, .local_node_o, .edge_index_o,
    .edge_first_o, .edge_second_o, .element_index_o, .overflow_o
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // offer one node; push stays high across back-to-back transfers
  task send_node(logic [12:0] num, logic eoe);
    int unsigned gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;  // stretches with no idling
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    node_number_i <= num;
    end_of_element_i <= eoe;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_node(num, eoe);
  endtask

  // pick a node: mostly a small shared pool so edges repeat, now and then any value
  function automatic logic [12:0] pick_node();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return 13'($urandom_range(1, 48));
    if (r < 95) return 13'($urandom_range(1, NSPACE));
    return 13'($urandom_range(0, 8191));
  endfunction

  // receiver: random pop gaps, one long hold-off on request
  initial begin
    res_t got;
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      got.kind = kind_e'(result_kind_o);
      got.last = last_result_o;
      got.local_node = local_node_o;
      got.edge_index = edge_index_o;
      got.edge_first = edge_first_o;
      got.edge_second = edge_second_o;
      got.elem = element_index_o;
      got.ovf = overflow_o;
      sb.check_result(got);
    end
  end

  // stimulus
  initial begin
    int unsigned sent, sides;
    bit held, paused;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty ring close on an invalid node
    send_node(13'd0, 1'b1);
    // single node ring at the top of the node space gives a self edge
    send_node(13'd4096, 1'b1);
    // invalid values above the node space
    send_node(13'd4097, 1'b0);
    send_node(13'd8191, 1'b0);
    send_node(13'd1, 1'b1);
    // two node ring: the return edge matches the first
    send_node(13'd2, 1'b0);
    send_node(13'd3, 1'b1);
    // triangle sharing an edge with the pair above
    send_node(13'd3, 1'b0);
    send_node(13'd2, 1'b0);
    send_node(13'd4, 1'b1);
    // full ring: seventeen nodes, the last one does not enter
    for (int i = 0; i < 17; i++) send_node(13'(10 + i), i == 16);

    // random polygons, mostly well formed
    sent = 0;
    held = 1'b0;
    paused = 1'b0;
    while (sent < 455) begin
      if (!held && sent >= 150) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent >= 300) begin
        paused = 1'b1;
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 9) == 0) sides = $urandom_range(1, 18);
      else sides = $urandom_range(3, 6);
      for (int i = 0; i < sides; i++) send_node(pick_node(), i == sides - 1);
      sent += sides;
    end
    push <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS polygon_mesh_edge_extractor_core");
    else
      $display("FAIL polygon_mesh_edge_extractor_core");
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("FAIL polygon_mesh_edge_extractor_core");
    $finish;
  end

endmodule

>>> polygon_mesh_edge_extractor_core.f
sv/mee_pkg.sv
sv/mee_fifo.sv
sv/mee_front.sv
sv/mee_back.sv
sv/polygon_mesh_edge_extractor_core.sv
bench/tb_polygon_mesh_edge_extractor_core.sv
